/* src/c8x_pkg.sv */
// shared types, constants and helpers for the chip8 execute core
package c8x_pkg;

  localparam int unsigned ADDR_W    = 12;
  localparam int unsigned MEM_BYTES = 4096;
  localparam int unsigned SCREEN_W  = 64;
  localparam int unsigned SCREEN_H  = 32;
  localparam int unsigned ROW_W     = $clog2(SCREEN_H);
  localparam int unsigned COL_W     = $clog2(SCREEN_W);

  localparam logic [ADDR_W-1:0] PC_RESET   = 12'h200;
  localparam logic [ADDR_W-1:0] FONT_RESET = 12'h050;

  // item kinds
  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_ROW   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // 8xyn sub-operations
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_RSB = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  // major opcode nibbles
  localparam logic [3:0] MAJ_SYS  = 4'h0;
  localparam logic [3:0] MAJ_JP   = 4'h1;
  localparam logic [3:0] MAJ_CALL = 4'h2;
  localparam logic [3:0] MAJ_SEI  = 4'h3;
  localparam logic [3:0] MAJ_SNEI = 4'h4;
  localparam logic [3:0] MAJ_SE   = 4'h5;
  localparam logic [3:0] MAJ_LDI  = 4'h6;
  localparam logic [3:0] MAJ_ADDI = 4'h7;
  localparam logic [3:0] MAJ_ALU  = 4'h8;
  localparam logic [3:0] MAJ_SNE  = 4'h9;
  localparam logic [3:0] MAJ_IDX  = 4'hA;
  localparam logic [3:0] MAJ_JPV  = 4'hB;
  localparam logic [3:0] MAJ_RND  = 4'hC;
  localparam logic [3:0] MAJ_DRW  = 4'hD;
  localparam logic [3:0] MAJ_KEY  = 4'hE;
  localparam logic [3:0] MAJ_MISC = 4'hF;

  localparam logic [15:0] INS_CLS = 16'h00E0;
  localparam logic [15:0] INS_RET = 16'h00EE;
  localparam logic [7:0]  KEY_SKP  = 8'h9E;
  localparam logic [7:0]  KEY_SKNP = 8'hA1;
  localparam logic [7:0]  F_GDT  = 8'h07;
  localparam logic [7:0]  F_WKEY = 8'h0A;
  localparam logic [7:0]  F_SDT  = 8'h15;
  localparam logic [7:0]  F_SST  = 8'h18;
  localparam logic [7:0]  F_ADDI = 8'h1E;
  localparam logic [7:0]  F_FONT = 8'h29;
  localparam logic [7:0]  F_BCD  = 8'h33;
  localparam logic [7:0]  F_DUMP = 8'h55;
  localparam logic [7:0]  F_LOAD = 8'h65;

  typedef struct packed {
    logic [1:0]        op;
    logic [15:0]       instruction;
    logic [15:0]       keys_down;
    logic [7:0]        random_byte;
    logic [ADDR_W-1:0] load_address;
    logic [7:0]        load_data;
  } c8x_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic              collision;
    logic              waiting_key;
    logic              stack_fault;
    logic              bad_opcode;
    logic [63:0]       screen_row;
    logic [7:0]        sound_level;
  } c8x_result_t;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       wr_flag;
    logic       bad;
  } c8x_alu_t;

  // decimal digits of a byte as {hundreds, tens, ones}
  function automatic logic [11:0] c8x_bcd(input logic [7:0] v);
    logic [3:0] h;
    logic [3:0] t;
    logic [7:0] r;
    logic [7:0] o;
    h = 4'd0;
    t = 4'd0;
    if (v >= 8'd200) h = 4'd2;
    else if (v >= 8'd100) h = 4'd1;
    r = v - 8'(h * 100);
    for (int k = 1; k < 10; k++) begin
      if (r >= 8'(k * 10)) t = 4'(k);
    end
    o = r - 8'(t * 10);
    return {h, t, o[3:0]};
  endfunction

endpackage

/* src/c8x_ram.sv */
// generic single write port ram with a registered read port
module c8x_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/c8x_alu.sv */
// register to register arithmetic of the 8xyn group with the vf flag
module c8x_alu import c8x_pkg::*; (
  input  logic [7:0] vx_i,
  input  logic [7:0] vy_i,
  input  logic [3:0] sub_i,
  output c8x_alu_t   out_o
);

  logic [8:0] sum;

  assign sum = {1'b0, vx_i} + {1'b0, vy_i};

  // sub-operation decode
  always_comb begin
    out_o = '0;
    unique case (sub_i)
      ALU_MOV: out_o.res = vy_i;
      ALU_OR:  out_o.res = vx_i | vy_i;
      ALU_AND: out_o.res = vx_i & vy_i;
      ALU_XOR: out_o.res = vx_i ^ vy_i;
      ALU_ADD: begin
        out_o.res = sum[7:0];
        out_o.flag = sum[8];
        out_o.wr_flag = 1'b1;
      end
      ALU_SUB: begin
        out_o.res = vx_i - vy_i;
        out_o.flag = (vx_i >= vy_i);
        out_o.wr_flag = 1'b1;
      end
      ALU_SHR: begin
        out_o.res = {1'b0, vx_i[7:1]};
        out_o.flag = vx_i[0];
        out_o.wr_flag = 1'b1;
      end
      ALU_RSB: begin
        out_o.res = vy_i - vx_i;
        out_o.flag = (vy_i >= vx_i);
        out_o.wr_flag = 1'b1;
      end
      ALU_SHL: begin
        out_o.res = {vx_i[6:0], 1'b0};
        out_o.flag = vx_i[7];
        out_o.wr_flag = 1'b1;
      end
      default: out_o.bad = 1'b1;
    endcase
  end

endmodule

/* src/chip8_instruction_execute.sv */
// chip8 execute core: sequencer around register, stack, memory and frame rams
//
//   channel   | signals                         | transaction
//   ----------+---------------------------------+-------------------------------
//   item      | start, busy, item_i             | start high while busy low
//   result    | done_o, result_o                | one cycle pulse, no back-pressure
//   config    | cfg_we_i, cfg_wdata_i           | cfg_we_i high at the edge
//
// memory writes and no-ops go straight to done, row reads pass the row state; most
// instructions read vx, vy, v0 and execute, flag-writing ones then write vf. draw
// reads and writes each sprite row, dump/load each register, bcd three digits. every
// state ram has one read and one write port. reset clears registers and frame via
// valid bits, so items are taken right after reset. results cannot be stalled.
module chip8_instruction_execute import c8x_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  c8x_item_t         item_i,
  output logic              done_o,
  output c8x_result_t       result_o,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i
);

  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LVW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MAW = $clog2(MEM_BYTES);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDX    = 4'd1;
  localparam logic [3:0] S_RDY    = 4'd2;
  localparam logic [3:0] S_RD0    = 4'd3;
  localparam logic [3:0] S_EXEC   = 4'd4;
  localparam logic [3:0] S_WRF    = 4'd5;
  localparam logic [3:0] S_DRD    = 4'd6;
  localparam logic [3:0] S_DWR    = 4'd7;
  localparam logic [3:0] S_DMPRD  = 4'd8;
  localparam logic [3:0] S_DMPWR  = 4'd9;
  localparam logic [3:0] S_LDRD   = 4'd10;
  localparam logic [3:0] S_LDWR   = 4'd11;
  localparam logic [3:0] S_BCD    = 4'd12;
  localparam logic [3:0] S_ROW    = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0] state_q, state_d;
  c8x_item_t it_q, it_d;
  logic [ADDR_W-1:0] pc_q, pc_d, idx_q, idx_d, font_q;
  logic [LVW-1:0] lvl_q, lvl_d;
  logic [7:0] delay_q, delay_d, sound_q, sound_d;
  logic [7:0] vx_q, vx_d, vy_q, vy_d, v0_q, v0_d;
  logic [3:0] cnt_q, cnt_d;
  logic hit_q, hit_d, flag_q, flag_d;
  logic coll_q, coll_d, wait_q, wait_d, sf_q, sf_d, bad_q, bad_d;
  logic [63:0] row_q, row_d;
  logic [15:0] vv_q, vv_d;
  logic [SCREEN_H-1:0] fv_q, fv_d;
  logic [3:0] vr_raddr_q;
  logic [ROW_W-1:0] fb_raddr_q;

  // ram ports
  logic vr_re, vr_we, fb_re, fb_we, mm_re, mm_we, st_re, st_we;
  logic [3:0] vr_raddr, vr_waddr;
  logic [7:0] vr_wdata, vr_rdata, vreg_rd;
  logic [ROW_W-1:0] fb_raddr, fb_waddr;
  logic [63:0] fb_wdata, fb_rdata, row_rd;
  logic [MAW-1:0] mm_raddr, mm_waddr;
  logic [7:0] mm_wdata, mm_rdata;
  logic [SAW-1:0] st_raddr, st_waddr;
  logic [ADDR_W-1:0] st_wdata, st_rdata;

  // decode helpers
  logic [15:0] ins;
  logic [3:0] xs, nib;
  logic [7:0] nn;
  logic [ADDR_W-1:0] nnn, idx_cnt;
  c8x_alu_t alu;
  logic [11:0] bcd;
  logic [3:0] key_num;
  logic key_any;
  logic [5:0] dy;
  logic [63:0] mask;
  logic [LVW-1:0] lvl_m1;

  assign ins = it_q.instruction;
  assign xs = ins[11:8];
  assign nib = ins[3:0];
  assign nn = ins[7:0];
  assign nnn = ins[11:0];
  assign idx_cnt = idx_q + ADDR_W'(cnt_q);
  assign bcd = c8x_bcd(vx_q);
  assign dy = {1'b0, vy_q[ROW_W-1:0]} + {2'b0, cnt_q};
  assign mask = {mm_rdata, 56'b0} >> vx_q[COL_W-1:0];
  assign lvl_m1 = lvl_q - LVW'(1);
  assign vreg_rd = vv_q[vr_raddr_q] ? vr_rdata : 8'd0;
  assign row_rd = fv_q[fb_raddr_q] ? fb_rdata : 64'd0;

  c8x_alu u_alu (
    .vx_i (vx_q),
    .vy_i (vy_q),
    .sub_i(nib),
    .out_o(alu)
  );

  // lowest pressed key
  always_comb begin
    key_num = 4'd0;
    key_any = |it_q.keys_down;
    for (int k = 15; k >= 0; k--) begin
      if (it_q.keys_down[k]) key_num = 4'(k);
    end
  end

  c8x_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
    .clk_i, .we_i(vr_we), .waddr_i(vr_waddr), .wdata_i(vr_wdata),
    .re_i(vr_re), .raddr_i(vr_raddr), .rdata_o(vr_rdata)
  );

  c8x_ram #(.WIDTH(64), .DEPTH(SCREEN_H)) u_frame (
    .clk_i, .we_i(fb_we), .waddr_i(fb_waddr), .wdata_i(fb_wdata),
    .re_i(fb_re), .raddr_i(fb_raddr), .rdata_o(fb_rdata)
  );

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk_i, .we_i(mm_we), .waddr_i(mm_waddr), .wdata_i(mm_wdata),
    .re_i(mm_re), .raddr_i(mm_raddr), .rdata_o(mm_rdata)
  );

  c8x_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .re_i(st_re), .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    it_d = it_q;
    pc_d = pc_q;
    idx_d = idx_q;
    lvl_d = lvl_q;
    delay_d = delay_q;
    sound_d = sound_q;
    vx_d = vx_q;
    vy_d = vy_q;
    v0_d = v0_q;
    cnt_d = cnt_q;
    hit_d = hit_q;
    flag_d = flag_q;
    coll_d = coll_q;
    wait_d = wait_q;
    sf_d = sf_q;
    bad_d = bad_q;
    row_d = row_q;
    vv_d = vv_q;
    fv_d = fv_q;
    vr_re = 1'b0;
    vr_raddr = xs;
    vr_we = 1'b0;
    vr_waddr = xs;
    vr_wdata = 8'd0;
    fb_re = 1'b0;
    fb_raddr = dy[ROW_W-1:0];
    fb_we = 1'b0;
    fb_waddr = dy[ROW_W-1:0];
    fb_wdata = row_rd ^ mask;
    mm_re = 1'b0;
    mm_raddr = idx_cnt;
    mm_we = 1'b0;
    mm_waddr = idx_cnt;
    mm_wdata = 8'd0;
    st_re = 1'b0;
    st_raddr = lvl_m1[SAW-1:0];
    st_we = 1'b0;
    st_waddr = lvl_q[SAW-1:0];
    st_wdata = pc_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          it_d = item_i;
          coll_d = 1'b0;
          wait_d = 1'b0;
          sf_d = 1'b0;
          bad_d = 1'b0;
          row_d = '0;
          state_d = S_DONE;
          case (item_i.op)
            OP_EXEC: begin
              pc_d = pc_q + ADDR_W'(2);
              vr_re = 1'b1;
              vr_raddr = item_i.instruction[11:8];
              st_re = (lvl_q != '0);
              state_d = S_RDX;
            end
            OP_LOAD: begin
              mm_we = 1'b1;
              mm_waddr = item_i.load_address;
              mm_wdata = item_i.load_data;
            end
            OP_ROW: begin
              fb_re = 1'b1;
              fb_raddr = item_i.load_address[ROW_W-1:0];
              state_d = S_ROW;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_ROW: begin
        if (it_q.load_address < ADDR_W'(SCREEN_H)) row_d = row_rd;
        state_d = S_DONE;
      end
      S_RDX: begin
        vx_d = vreg_rd;
        vr_re = 1'b1;
        vr_raddr = ins[7:4];
        state_d = S_RDY;
      end
      S_RDY: begin
        vy_d = vreg_rd;
        vr_re = 1'b1;
        vr_raddr = 4'd0;
        state_d = S_RD0;
      end
      S_RD0: begin
        v0_d = vreg_rd;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        cnt_d = 4'd0;
        hit_d = 1'b0;
        unique case (ins[15:12])
          MAJ_SYS: begin
            if (ins == INS_CLS) begin
              fv_d = '0;
            end else if (ins == INS_RET) begin
              if (lvl_q == '0) sf_d = 1'b1;
              else begin
                lvl_d = lvl_m1;
                pc_d = st_rdata;
              end
            end else begin
              bad_d = 1'b1;
            end
          end
          MAJ_JP: pc_d = nnn;
          MAJ_CALL: begin
            if (lvl_q >= LVW'(STACK_DEPTH)) sf_d = 1'b1;
            else begin
              st_we = 1'b1;
              lvl_d = lvl_q + LVW'(1);
              pc_d = nnn;
            end
          end
          MAJ_SEI: if (vx_q == nn) pc_d = pc_q + ADDR_W'(2);
          MAJ_SNEI: if (vx_q != nn) pc_d = pc_q + ADDR_W'(2);
          MAJ_SE, MAJ_SNE: begin
            if (nib != 4'd0) bad_d = 1'b1;
            else if ((vx_q == vy_q) == (ins[15:12] == MAJ_SE)) pc_d = pc_q + ADDR_W'(2);
          end
          MAJ_LDI: begin
            vr_we = 1'b1;
            vr_wdata = nn;
          end
          MAJ_ADDI: begin
            vr_we = 1'b1;
            vr_wdata = vx_q + nn;
          end
          MAJ_ALU: begin
            if (alu.bad) bad_d = 1'b1;
            else begin
              vr_we = 1'b1;
              vr_wdata = alu.res;
              flag_d = alu.flag;
              if (alu.wr_flag) state_d = S_WRF;
            end
          end
          MAJ_IDX: idx_d = nnn;
          MAJ_JPV: pc_d = nnn + ADDR_W'(v0_q);
          MAJ_RND: begin
            vr_we = 1'b1;
            vr_wdata = it_q.random_byte & nn;
          end
          MAJ_DRW: begin
            if (nib == 4'd0) begin
              flag_d = 1'b0;
              state_d = S_WRF;
            end else begin
              state_d = S_DRD;
            end
          end
          MAJ_KEY: begin
            if (nn == KEY_SKP) begin
              if (it_q.keys_down[vx_q[3:0]]) pc_d = pc_q + ADDR_W'(2);
            end else if (nn == KEY_SKNP) begin
              if (!it_q.keys_down[vx_q[3:0]]) pc_d = pc_q + ADDR_W'(2);
            end else begin
              bad_d = 1'b1;
            end
          end
          MAJ_MISC: begin
            case (nn)
              F_GDT: begin
                vr_we = 1'b1;
                vr_wdata = delay_q;
              end
              F_WKEY: begin
                if (key_any) begin
                  vr_we = 1'b1;
                  vr_wdata = {4'd0, key_num};
                end else begin
                  pc_d = pc_q - ADDR_W'(2);
                  wait_d = 1'b1;
                end
              end
              F_SDT: delay_d = vx_q;
              F_SST: sound_d = vx_q;
              F_ADDI: idx_d = idx_q + ADDR_W'(vx_q);
              F_FONT: idx_d = font_q + ADDR_W'({1'b0, vx_q[3:0], 2'b0} + {3'b0, vx_q[3:0]});
              F_BCD: state_d = S_BCD;
              F_DUMP: state_d = S_DMPRD;
              F_LOAD: state_d = S_LDRD;
              default: bad_d = 1'b1;
            endcase
          end
          default: bad_d = 1'b1;
        endcase
      end
      S_WRF: begin
        vr_we = 1'b1;
        vr_waddr = 4'hF;
        vr_wdata = {7'd0, flag_q};
        state_d = S_DONE;
      end
      S_DRD: begin
        mm_re = 1'b1;
        fb_re = 1'b1;
        state_d = S_DWR;
      end
      S_DWR: begin
        fb_we = 1'b1;
        fv_d[dy[ROW_W-1:0]] = 1'b1;
        hit_d = hit_q | (|(row_rd & mask));
        if ((cnt_q == nib - 4'd1) || (dy == 6'(SCREEN_H - 1))) begin
          flag_d = hit_d;
          coll_d = hit_d;
          state_d = S_WRF;
        end else begin
          cnt_d = cnt_q + 4'd1;
          state_d = S_DRD;
        end
      end
      S_DMPRD: begin
        vr_re = 1'b1;
        vr_raddr = cnt_q;
        state_d = S_DMPWR;
      end
      S_DMPWR: begin
        mm_we = 1'b1;
        mm_wdata = vreg_rd;
        cnt_d = cnt_q + 4'd1;
        state_d = (cnt_q == xs) ? S_DONE : S_DMPRD;
      end
      S_LDRD: begin
        mm_re = 1'b1;
        state_d = S_LDWR;
      end
      S_LDWR: begin
        vr_we = 1'b1;
        vr_waddr = cnt_q;
        vr_wdata = mm_rdata;
        cnt_d = cnt_q + 4'd1;
        state_d = (cnt_q == xs) ? S_DONE : S_LDRD;
      end
      S_BCD: begin
        mm_we = 1'b1;
        case (cnt_q[1:0])
          2'd0: mm_wdata = {4'd0, bcd[11:8]};
          2'd1: mm_wdata = {4'd0, bcd[7:4]};
          default: mm_wdata = {4'd0, bcd[3:0]};
        endcase
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd2) state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    if (vr_we) vv_d[vr_waddr] = 1'b1;
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q <= PC_RESET;
      idx_q <= '0;
      lvl_q <= '0;
      delay_q <= '0;
      sound_q <= '0;
      vv_q <= '0;
      fv_q <= '0;
      font_q <= FONT_RESET;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      idx_q <= idx_d;
      lvl_q <= lvl_d;
      delay_q <= delay_d;
      sound_q <= sound_d;
      vv_q <= vv_d;
      fv_q <= fv_d;
      if (cfg_we_i) font_q <= cfg_wdata_i;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    it_q <= it_d;
    vx_q <= vx_d;
    vy_q <= vy_d;
    v0_q <= v0_d;
    cnt_q <= cnt_d;
    hit_q <= hit_d;
    flag_q <= flag_d;
    coll_q <= coll_d;
    wait_q <= wait_d;
    sf_q <= sf_d;
    bad_q <= bad_d;
    row_q <= row_d;
    if (vr_re) vr_raddr_q <= vr_raddr;
    if (fb_re) fb_raddr_q <= fb_raddr;
  end

  // result transaction
  assign busy = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  always_comb begin
    result_o.next_pc = pc_q;
    result_o.collision = coll_q;
    result_o.waiting_key = wait_q;
    result_o.stack_fault = sf_q;
    result_o.bad_opcode = bad_q;
    result_o.screen_row = row_q;
    result_o.sound_level = sound_q;
  end

  // checks
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy) else $error("result strobe longer than one cycle");
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LVW'(STACK_DEPTH)) else $error("stack level beyond depth");
  a_pc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> $stable(pc_q)) else $error("pc moved while idle");

endmodule
